>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the cache tag engine core module.
// All of them sample on clock and are switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

>>> rtl/core/sactl_pkg.sv
// ----------------------------------------------------------------------------
// sactl_pkg
// Geometry, row layout and shared types of the set-associative tag engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sactl_pkg;

   // cache geometry
   localparam int NUM_SETS   = 64;
   localparam int NUM_WAYS   = 2;
   localparam int LINE_BYTES = 32;

   localparam int ADDR_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int OFFSET_W = $clog2(LINE_BYTES);
   localparam int SET_W    = $clog2(NUM_SETS);
   localparam int TAG_W    = ADDR_W - OFFSET_W - SET_W;
   localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int AGE_W    = WAY_W;

   // result beat layout
   localparam int RSP_USED_W = 2 + WAY_W + SET_W + 5 * COUNT_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   // one line of a set as held in the tag memory
   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [AGE_W-1:0] age;
      logic [TAG_W-1:0] tag;
   } line_type;

   typedef line_type [NUM_WAYS-1:0] row_type;

   // outcome of one lookup, passed on to the counters
   typedef struct packed {
      logic             hit;
      logic             writeback;
      logic [WAY_W-1:0] way;
      logic             store;
   } event_type;

   typedef struct packed {
      logic [COUNT_W-1:0] hits;
      logic [COUNT_W-1:0] misses;
      logic [COUNT_W-1:0] writebacks;
      logic [COUNT_W-1:0] loads;
      logic [COUNT_W-1:0] stores;
   } totals_type;

   // contents of a set that was never written: all invalid, age = way index
   function automatic row_type reset_row();
      row_type r;
      for (int w = 0; w < NUM_WAYS; w++) begin
         r[w]     = '0;
         r[w].age = AGE_W'(w);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sactl_tag_ram.sv
// ----------------------------------------------------------------------------
// sactl_tag_ram
// Tag memory, one row per set, registered read. A row that has never
// been written reads as the reset contents.
// ----------------------------------------------------------------------------
`default_nettype none

module sactl_tag_ram (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [sactl_pkg::SET_W-1:0] rd_addr,
   output      sactl_pkg::row_type          rd_row,
   input  wire logic                        wr_en,
   input  wire logic [sactl_pkg::SET_W-1:0] wr_addr,
   input  wire sactl_pkg::row_type          wr_row
);

   sactl_pkg::row_type                    mem [sactl_pkg::NUM_SETS];
   logic [sactl_pkg::NUM_SETS-1:0]        written_ff;
   logic [sactl_pkg::NUM_SETS-1:0]        written_in;
   sactl_pkg::row_type                    rd_data_ff;
   logic                                  rd_written_ff;

   // row write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // per-row written flags
   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff <= written_in;
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_written_ff ? rd_data_ff : sactl_pkg::reset_row();

endmodule

`default_nettype wire

>>> rtl/core/sactl_replace.sv
// ----------------------------------------------------------------------------
// sactl_replace
// Way compare, victim choice and age update for one set row.
// ----------------------------------------------------------------------------
`default_nettype none

module sactl_replace (
   input  wire sactl_pkg::row_type          row,
   input  wire logic [sactl_pkg::TAG_W-1:0] tag,
   input  wire logic                        store,
   output      sactl_pkg::row_type          new_row,
   output      sactl_pkg::event_type        evt
);

   logic                              hit;
   logic                              found_free;
   logic                              found_old;
   logic [sactl_pkg::WAY_W-1:0]       hit_way;
   logic [sactl_pkg::WAY_W-1:0]       free_way;
   logic [sactl_pkg::WAY_W-1:0]       old_way;
   logic [sactl_pkg::WAY_W-1:0]       way;
   logic [sactl_pkg::AGE_W-1:0]       cur_age;
   logic                              wb;

   // lowest valid matching way, lowest invalid way, oldest way
   always_comb begin
      hit        = 1'b0;
      found_free = 1'b0;
      found_old  = 1'b0;
      hit_way    = '0;
      free_way   = '0;
      old_way    = '0;
      for (int w = 0; w < sactl_pkg::NUM_WAYS; w++) begin
         if (!hit && row[w].valid && row[w].tag == tag) begin
            hit     = 1'b1;
            hit_way = sactl_pkg::WAY_W'(w);
         end
         if (!found_free && !row[w].valid) begin
            found_free = 1'b1;
            free_way   = sactl_pkg::WAY_W'(w);
         end
         if (!found_old && row[w].age == sactl_pkg::AGE_W'(sactl_pkg::NUM_WAYS - 1)) begin
            found_old = 1'b1;
            old_way   = sactl_pkg::WAY_W'(w);
         end
      end
   end

   // chosen way: hit, else free, else oldest (way 0 if ages were corrupt)
   always_comb begin
      priority if (hit) begin
         way = hit_way;
      end else if (found_free) begin
         way = free_way;
      end else if (found_old) begin
         way = old_way;
      end else begin
         way = '0;
      end
   end

   assign cur_age = row[way].age;
   assign wb      = !hit && row[way].valid && row[way].dirty;

   // touch the chosen way and install or mark dirty
   always_comb begin
      new_row = row;
      for (int w = 0; w < sactl_pkg::NUM_WAYS; w++) begin
         if (sactl_pkg::WAY_W'(w) == way) begin
            new_row[w].age = '0;
         end else if (row[w].age < cur_age) begin
            new_row[w].age = row[w].age + 1'b1;
         end
      end
      if (hit) begin
         new_row[way].dirty = row[way].dirty | store;
      end else begin
         new_row[way].tag   = tag;
         new_row[way].valid = 1'b1;
         new_row[way].dirty = store;
      end
   end

   assign evt.hit       = hit;
   assign evt.writeback = wb;
   assign evt.way       = way;
   assign evt.store     = store;

endmodule

`default_nettype wire

>>> rtl/core/sactl_counters.sv
// ----------------------------------------------------------------------------
// sactl_counters
// Saturating hit, miss, writeback, load and store counters. totals shows the
// values that apply after the pending event is committed.
// ----------------------------------------------------------------------------
`default_nettype none

module sactl_counters (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 commit,
   input  wire sactl_pkg::event_type evt,
   output      sactl_pkg::totals_type totals
);

   sactl_pkg::totals_type totals_ff;
   sactl_pkg::totals_type totals_in;

   function automatic logic [sactl_pkg::COUNT_W-1:0] sat_inc(
      input logic [sactl_pkg::COUNT_W-1:0] v,
      input logic                          en
   );
      return (en && v != '1) ? v + 1'b1 : v;
   endfunction

   // next counts for the event under lookup
   always_comb begin
      totals_in.hits       = sat_inc(totals_ff.hits, evt.hit);
      totals_in.misses     = sat_inc(totals_ff.misses, !evt.hit);
      totals_in.writebacks = sat_inc(totals_ff.writebacks, evt.writeback);
      totals_in.loads      = sat_inc(totals_ff.loads, !evt.store);
      totals_in.stores     = sat_inc(totals_ff.stores, evt.store);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         totals_ff <= '0;
      end else if (commit) begin
         totals_ff <= totals_in;
      end
   end

   assign totals = totals_in;

endmodule

`default_nettype wire

>>> rtl/core/set_assoc_cache_lru_tracker_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tracker_core
// Tag and LRU replacement engine of a set-associative write-back cache.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per load or store; tuser = kind (1 = store),
//            tdata = byte address.
//   rsp_*  : one beat per request: hit, writeback, chosen way, set index and
//            the five saturating event totals after that access.
//   A request accepted in idle reads its set row into the tag memory read
//   register; the lookup then updates and writes the row back and loads the
//   result into the output register (rsp_tvalid). A new request is taken only
//   after that read-modify-write of the set row is done (req_tready in idle).
//   The output register frees the request side: a new request is taken while
//   an earlier result is still waiting on rsp_tready. If the receiver stalls
//   with a result pending, the next lookup holds until the register empties.
//   Reset (synchronous) clears the counters, the per-set written flags and the
//   handshake state; no clearing sweep of the tag memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module set_assoc_cache_lru_tracker_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [sactl_pkg::ADDR_W-1:0]     req_tdata,  // address
   input  wire logic                             req_tuser,  // kind
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata from bit 0: hit, writeback, chosen_way, set_index, hit_total,
   // miss_total, writeback_total, load_total, store_total, zero fill
   output      logic [sactl_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_LOOKUP = 2'b10
   } state_type;

   state_type                          state_ff;
   state_type                          state_in;
   logic                               req_accept;
   logic                               lookup_fire;
   logic [sactl_pkg::SET_W-1:0]        req_set;
   logic [sactl_pkg::SET_W-1:0]        set_ff;
   logic [sactl_pkg::TAG_W-1:0]        tag_ff;
   logic                               store_ff;
   sactl_pkg::row_type                 rd_row;
   sactl_pkg::row_type                 new_row;
   sactl_pkg::event_type               evt;
   sactl_pkg::totals_type              totals;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [sactl_pkg::RSP_DATA_W-1:0]   rsp_data_ff;

   // handshake
   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign lookup_fire = (state_ff == S_LOOKUP) && (!rsp_valid_ff || rsp_tready);
   assign req_set     = req_tdata[sactl_pkg::OFFSET_W +: sactl_pkg::SET_W];

   // request fields held for the lookup cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         set_ff   <= req_set;
         tag_ff   <= req_tdata[sactl_pkg::ADDR_W-1 -: sactl_pkg::TAG_W];
         store_ff <= req_tuser;
      end
   end

   sactl_tag_ram u_tag_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_set),
      .rd_row  (rd_row),
      .wr_en   (lookup_fire),
      .wr_addr (set_ff),
      .wr_row  (new_row)
   );

   sactl_replace u_replace (
      .row     (rd_row),
      .tag     (tag_ff),
      .store   (store_ff),
      .new_row (new_row),
      .evt     (evt)
   );

   sactl_counters u_counters (
      .clock  (clock),
      .reset  (reset),
      .commit (lookup_fire),
      .evt    (evt),
      .totals (totals)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (lookup_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (lookup_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_fire) begin
         rsp_data_ff <= sactl_pkg::RSP_DATA_W'({totals.stores, totals.loads,
                                                totals.writebacks, totals.misses,
                                                totals.hits, set_ff, evt.way,
                                                evt.writeback, evt.hit});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `ASSERT_ALWAYS(a_accept_to_lookup, req_accept |=> (state_ff == S_LOOKUP && !req_tready), "request accepted but no lookup follows")
   `ASSERT_ALWAYS(a_fire_loads_rsp, lookup_fire |=> rsp_tvalid, "lookup finished without a result beat")
   `ASSERT_NEVER(a_fire_overwrites, lookup_fire && rsp_valid_ff && !rsp_tready, "pending result overwritten")
   `ASSERT_NEVER(a_hit_writeback, lookup_fire && evt.hit && evt.writeback, "writeback reported on a hit")

endmodule

`default_nettype wire
